@@ rtl/dhsc_pkg.sv @@
`default_nettype none
package dhsc_pkg;

  localparam int DEF_MAX_REQUESTS = 32;
  localparam int DEF_CYL_BITS     = 16;

  // Fixed field widths of the ports.
  localparam int FIELD_CYL_BITS = 16;
  localparam int MOVE_BITS      = 22;
  localparam int COUNT_BITS     = 6;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [MOVE_BITS-1:0] MOVE_MAX = {MOVE_BITS{1'b1}};

  localparam logic [2:0] POL_FCFS  = 3'd0;
  localparam logic [2:0] POL_SSTF  = 3'd1;
  localparam logic [2:0] POL_SCAN  = 3'd2;
  localparam logic [2:0] POL_CSCAN = 3'd3;
  localparam logic [2:0] POL_LOOK  = 3'd4;
  localparam logic [2:0] POL_CLOOK = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] REG_POLICY   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_UP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAST_CYL = 2'd2;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/dhsc_cell.sv @@
`default_nettype none
module dhsc_cell #(
  parameter int CYL_BITS = dhsc_pkg::DEF_CYL_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dhsc_pkg::cell_ctrl_t ctrl,
  input  wire logic                 mark,
  input  wire logic [CYL_BITS-1:0]  in_value,
  input  wire logic                 in_served,
  output logic      [CYL_BITS-1:0]  value,
  output logic                      served
);
  import dhsc_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      served <= 1'b0;
    end else if (mark) begin
      served <= 1'b1;
    end else if (ctrl.shift) begin
      served <= in_served;
    end
  end

endmodule
`default_nettype wire

@@ rtl/disk_head_seek_cost_core.sv @@
`default_nettype none
// Add words (op 0) go into a ring of request cells; a cylinder beyond
// last_cylinder, or one arriving with the batch full, is dropped. A run
// word (op 1) rotates the ring past a single evaluation unit,
// one cell per cycle, pausing for each SSTF marking step. A run is one full
// turn of the ring for FCFS, a full turn and a closing step for the four
// sweep policies, a full turn and a marking step for each request served
// for SSTF, and no turn for an empty batch. The result appears for one
// cycle with done high and must be taken then, since the receiver cannot
// stall; busy stays high until that cycle.
module disk_head_seek_cost_core #(
  parameter int MAX_REQUESTS = dhsc_pkg::DEF_MAX_REQUESTS,
  parameter int CYL_BITS     = dhsc_pkg::DEF_CYL_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 op,
  input  wire logic [dhsc_pkg::FIELD_CYL_BITS-1:0]  cyl_value,
  input  wire logic                                 cfg_we,
  input  wire logic [dhsc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [dhsc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                      done,
  output logic      [dhsc_pkg::MOVE_BITS-1:0]       total_movement,
  output logic      [dhsc_pkg::COUNT_BITS-1:0]      served_count
);
  import dhsc_pkg::*;

  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int SUM_W = ((MOVE_BITS > CYL_BITS) ? MOVE_BITS : CYL_BITS) + 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REQUESTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PASS = 5'b00010,
    ST_MARK = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  function automatic logic [CYL_BITS-1:0] absdiff(input logic [CYL_BITS-1:0] a,
                                                  input logic [CYL_BITS-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [MOVE_BITS-1:0] sat(input logic [SUM_W-1:0] s);
    sat = (s > SUM_W'(MOVE_MAX)) ? MOVE_MAX : s[MOVE_BITS-1:0];
  endfunction

  state_t state, state_next;

  logic [2:0]          policy;
  logic                sweep_up;
  logic [CYL_BITS-1:0] last_cylinder;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    steps;
  logic [IDX_W-1:0]    p;
  logic [CYL_BITS-1:0] head, pos;
  logic [MOVE_BITS-1:0] acc;
  logic                found;
  logic [CYL_BITS-1:0] bd, bestv;
  logic [IDX_W-1:0]    best;
  logic                has_a, has_b;
  logic [CYL_BITS-1:0] min_a, max_a, min_b, max_b;
  logic [CYL_BITS-1:0] t1, t2;
  logic [CYL_BITS:0]   t3;

  logic [CYL_BITS-1:0] cyl, top;
  logic                accept, load;
  logic                is_sstf, is_sorted;
  logic                tap_valid;
  logic [CYL_BITS-1:0] tap_value, tap_dist;
  logic                tap_served;
  cell_ctrl_t          ctrl;

  logic [CYL_BITS-1:0] cval [MAX_REQUESTS];
  logic                csrv [MAX_REQUESTS];

  assign cyl       = CYL_BITS'(cyl_value);
  assign top       = last_cylinder;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load      = accept && (op == OP_ADD) && (cyl <= top) &&
                     (count < CNT_W'(MAX_REQUESTS));
  assign is_sstf   = (policy == POL_SSTF);
  assign is_sorted = (policy == POL_SCAN) || (policy == POL_CSCAN) ||
                     (policy == POL_LOOK) || (policy == POL_CLOOK);

  assign ctrl.shift = load || (state == ST_PASS);
  assign ctrl.clear = accept && (op == OP_RUN);

  // The cells rotate toward cell 0; new words enter at the far end, so the
  // n valid requests occupy the last n places of a full turn, oldest first.
  for (genvar k = 0; k < MAX_REQUESTS; k++) begin : g_cell
    logic [CYL_BITS-1:0] in_v;
    logic                in_s;
    if (k == MAX_REQUESTS - 1) begin : g_tail
      assign in_v = load ? cyl : cval[0];
      assign in_s = load ? 1'b0 : csrv[0];
    end else begin : g_body
      assign in_v = cval[k+1];
      assign in_s = csrv[k+1];
    end
    dhsc_cell #(.CYL_BITS(CYL_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .mark      ((state == ST_MARK) && (best == IDX_W'(k))),
      .in_value  (in_v),
      .in_served (in_s),
      .value     (cval[k]),
      .served    (csrv[k])
    );
  end

  assign tap_value  = cval[0];
  assign tap_served = csrv[0];
  assign tap_dist   = absdiff(pos, tap_value);
  assign tap_valid  = ((CNT_W+1)'(p) + (CNT_W+1)'(count)) >= (CNT_W+1)'(MAX_REQUESTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POL_FCFS;
      sweep_up      <= 1'b1;
      last_cylinder <= CYL_BITS'(199);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY:   policy        <= cfg_data[2:0];
        REG_SWEEP_UP: sweep_up      <= cfg_data[0];
        REG_LAST_CYL: last_cylinder <= CYL_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_RUN)) begin
          state_next = (count == '0) ? ST_DONE : ST_PASS;
        end
      end
      ST_PASS: begin
        if (p == LAST_IDX) begin
          if (is_sstf) begin
            state_next = ST_MARK;
          end else if (is_sorted) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MARK: state_next = (steps == CNT_W'(1)) ? ST_DONE : ST_PASS;
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (load) begin
        count <= count + CNT_W'(1);
      end else if (state == ST_DONE) begin
        count <= '0;
      end
    end
  end

  // Closing terms of the sweep policies, from the extremes on each side of
  // the head. The first term is the walk in the starting direction.
  // Requests loaded under a larger last_cylinder can lie beyond the disk end,
  // so the walk back from the end starts with an absolute difference.
  logic [CYL_BITS-1:0] pos1, f1, f2;
  logic [CYL_BITS:0]   f3;
  always_comb begin
    f2 = '0;
    f3 = '0;
    if (sweep_up) begin
      pos1 = has_a ? max_a : head;
      f1   = has_a ? (max_a - head) : '0;
      priority case (policy)
        POL_SCAN: begin
          f2 = absdiff(top, pos1);
          f3 = has_b ? ((CYL_BITS+1)'(absdiff(top, max_b)) +
                        (CYL_BITS+1)'(max_b - min_b)) : '0;
        end
        POL_CSCAN: begin
          f2 = absdiff(top, pos1);
          f3 = has_b ? (CYL_BITS+1)'(max_b) : '0;
        end
        POL_LOOK: f2 = has_b ? (pos1 - min_b) : '0;
        default:  f2 = has_b ? (max_b - min_b) : '0;
      endcase
    end else begin
      pos1 = has_b ? min_b : head;
      f1   = has_b ? (head - min_b) : '0;
      priority case (policy)
        POL_SCAN: begin
          f2 = pos1;
          f3 = has_a ? (CYL_BITS+1)'(max_a) : '0;
        end
        POL_CSCAN: begin
          f2 = pos1;
          f3 = has_a ? ((CYL_BITS+1)'(absdiff(top, max_a)) +
                        (CYL_BITS+1)'(max_a - min_a)) : '0;
        end
        POL_LOOK: f2 = has_a ? (max_a - pos1) : '0;
        default:  f2 = has_a ? (max_a - min_a) : '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        p     <= '0;
        found <= 1'b0;
        has_a <= 1'b0;
        has_b <= 1'b0;
        acc   <= '0;
        t1    <= '0;
        t2    <= '0;
        t3    <= '0;
        head  <= cyl;
        pos   <= cyl;
        steps <= count;
      end
      ST_PASS: begin
        p <= (p == LAST_IDX) ? '0 : p + IDX_W'(1);
        if (tap_valid) begin
          if (is_sstf) begin
            // Strict compare keeps the earliest request on a tie.
            if (!tap_served && (!found || tap_dist < bd)) begin
              found <= 1'b1;
              bd    <= tap_dist;
              best  <= p;
              bestv <= tap_value;
            end
          end else if (is_sorted) begin
            if (tap_value <= head) begin
              has_b <= 1'b1;
              if (!has_b || tap_value < min_b) min_b <= tap_value;
              if (!has_b || tap_value > max_b) max_b <= tap_value;
            end else begin
              has_a <= 1'b1;
              if (!has_a || tap_value < min_a) min_a <= tap_value;
              if (!has_a || tap_value > max_a) max_a <= tap_value;
            end
          end else begin
            acc <= sat(SUM_W'(acc) + SUM_W'(tap_dist));
            pos <= tap_value;
          end
        end
      end
      ST_MARK: begin
        acc   <= sat(SUM_W'(acc) + SUM_W'(bd));
        pos   <= bestv;
        steps <= steps - CNT_W'(1);
        found <= 1'b0;
      end
      ST_FIN: begin
        t1 <= f1;
        t2 <= f2;
        t3 <= f3;
      end
      ST_DONE: begin
        total_movement <= sat(SUM_W'(acc) + SUM_W'(t1) + SUM_W'(t2) + SUM_W'(t3));
        served_count   <= COUNT_BITS'(count);
      end
      default: ;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word shown while busy");
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a run");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REQUESTS))
    else $error("batch count beyond capacity");

endmodule
`default_nettype wire

@@ sim/seek_checker.sv @@
module seek_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [15:0] cyl_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        done,
  input  logic [21:0] total_movement,
  input  logic [5:0]  served_count,
  output int          fail_count,
  output int          pending
);
  import dhsc_pkg::*;

  typedef struct {
    logic [21:0] move;
    logic [5:0]  cnt;
  } seek_result_t;

  seek_result_t results_due[$];
  logic [15:0]  batch[32];
  int unsigned  batch_len;
  logic [2:0]   pol;
  logic         sweep;
  logic [15:0]  top_cyl;

  function automatic longint gap(input int unsigned a, input int unsigned b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic longint seek_total(input logic [15:0] head);
    longint      tot;
    longint      bd;
    int unsigned s[32];
    int unsigned n, i, j, split, pos, v, best;
    bit          taken[32];
    bit          found;
    tot = 0;
    n = batch_len;
    pos = head;
    if (n == 0) return 0;
    if (pol == POL_SSTF) begin
      for (i = 0; i < 32; i++) taken[i] = 0;
      for (j = 0; j < n; j++) begin
        found = 0;
        best = 0;
        bd = 0;
        // Strict comparison keeps the earliest arrival on a tie.
        for (i = 0; i < n; i++) begin
          if (!taken[i] && (!found || gap(pos, batch[i]) < bd)) begin
            found = 1;
            best = i;
            bd = gap(pos, batch[i]);
          end
        end
        taken[best] = 1;
        tot += bd;
        pos = batch[best];
      end
      return tot;
    end
    if (pol < POL_SCAN || pol > POL_CLOOK) begin
      for (i = 0; i < n; i++) begin
        tot += gap(pos, batch[i]);
        pos = batch[i];
      end
      return tot;
    end
    for (i = 0; i < n; i++) s[i] = batch[i];
    for (i = 1; i < n; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    split = 0;
    while (split < n && s[split] <= head) split++;
    if (sweep) begin
      for (i = split; i < n; i++) begin tot += gap(pos, s[i]); pos = s[i]; end
      if (pol == POL_SCAN || pol == POL_CSCAN) begin
        tot += gap(top_cyl, pos);
        pos = (pol == POL_SCAN) ? top_cyl : 0;
      end else if (pol == POL_CLOOK) begin
        pos = s[0];
      end
      if (pol == POL_SCAN || pol == POL_LOOK) begin
        for (i = split; i > 0; i--) begin tot += gap(pos, s[i-1]); pos = s[i-1]; end
      end else begin
        for (i = 0; i < split; i++) begin tot += gap(pos, s[i]); pos = s[i]; end
      end
    end else begin
      for (i = split; i > 0; i--) begin tot += gap(pos, s[i-1]); pos = s[i-1]; end
      if (pol == POL_SCAN || pol == POL_CSCAN) begin
        tot += pos;
        pos = (pol == POL_SCAN) ? 0 : top_cyl;
      end else if (pol == POL_CLOOK) begin
        pos = s[n-1];
      end
      if (pol == POL_SCAN || pol == POL_LOOK) begin
        for (i = split; i < n; i++) begin tot += gap(pos, s[i]); pos = s[i]; end
      end else begin
        for (i = n; i > split; i--) begin tot += gap(pos, s[i-1]); pos = s[i-1]; end
      end
    end
    return tot;
  endfunction

  always @(posedge clk) begin
    seek_result_t want;
    longint       tot;
    if (rst) begin
      results_due.delete();
      batch_len = 0;
      pol = POL_FCFS;
      sweep = 1'b1;
      top_cyl = 16'd199;
      fail_count = 0;
    end else begin
      if (done) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: move %0d count %0d", total_movement, served_count);
        end else begin
          want = results_due.pop_front();
          if (want.move !== total_movement || want.cnt !== served_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: move exp %0d got %0d, count exp %0d got %0d",
                       want.move, total_movement, want.cnt, served_count);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY:   pol = cfg_data[2:0];
          REG_SWEEP_UP: sweep = cfg_data[0];
          REG_LAST_CYL: top_cyl = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (op == OP_ADD) begin
          if (cyl_value <= top_cyl && batch_len < 32) begin
            batch[batch_len] = cyl_value;
            batch_len++;
          end
        end else begin
          tot = seek_total(cyl_value);
          want.move = (tot > 64'd4194303) ? MOVE_MAX : tot[21:0];
          want.cnt = batch_len[5:0];
          results_due = {results_due, want};
          batch_len = 0;
        end
      end
    end
    pending = results_due.size();
  end

endmodule

@@ sim/testbench.sv @@
module testbench;
  import dhsc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [15:0] cyl_value;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        done;
  logic [21:0] total_movement;
  logic [5:0]  served_count;
  int          fail_count;
  int          pending;
  int          stall_cycles;
  int          words_sent;
  bit          quiet;
  logic [15:0] cur_last;

  disk_head_seek_cost_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .cyl_value(cyl_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .total_movement(total_movement), .served_count(served_count)
  );

  seek_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .cyl_value(cyl_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .total_movement(total_movement), .served_count(served_count),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("disk_head_seek_cost_core regression: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with start still high.
  // Busy only moves at rising edges, so low busy here means the word is taken
  // at the next rising edge.
  task automatic send_word(input logic kind, input logic [15:0] value);
    if (!quiet && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    op <= kind;
    cyl_value <= value;
    while (busy) @(negedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    if (idx == REG_LAST_CYL) cur_last = value;
  endtask

  task automatic set_config(input logic [2:0] pol, input logic up, input logic [15:0] last);
    drain();
    write_reg(REG_POLICY, {13'd0, pol});
    write_reg(REG_SWEEP_UP, {15'd0, up});
    write_reg(REG_LAST_CYL, last);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_cyl();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return cur_last;
      2: return 16'($urandom_range(0, 65535));
      3: return (cur_last == 16'hFFFF) ? 16'hFFFF : cur_last + 16'd1;
      default: return 16'($urandom_range(0, cur_last));
    endcase
  endfunction

  initial begin
    int n;
    int k;
    logic [15:0] last;
    rst = 1'b1;
    start = 1'b0;
    op = OP_ADD;
    cyl_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 0;
    words_sent = 0;
    cur_last = 16'd199;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: extreme cylinders, drops, an SSTF tie, empty batch, head beyond the disk.
    set_config(POL_FCFS, 1'b1, 16'hFFFF);
    send_word(OP_ADD, 16'd0);
    send_word(OP_ADD, 16'hFFFF);
    send_word(OP_RUN, 16'hFFFF);
    set_config(POL_SSTF, 1'b1, 16'd199);
    send_word(OP_ADD, 16'd30);
    send_word(OP_ADD, 16'd10);
    send_word(OP_ADD, 16'd200);
    send_word(OP_RUN, 16'd20);
    send_word(OP_RUN, 16'd5);
    set_config(POL_SCAN, 1'b1, 16'd99);
    send_word(OP_ADD, 16'd50);
    send_word(OP_ADD, 16'd99);
    send_word(OP_RUN, 16'd300);
    set_config(POL_CLOOK, 1'b0, 16'd99);
    send_word(OP_ADD, 16'd10);
    send_word(OP_ADD, 16'd80);
    send_word(OP_ADD, 16'd40);
    send_word(OP_RUN, 16'd40);
    set_config(3'd7, 1'b0, 16'd0);
    send_word(OP_ADD, 16'd0);
    send_word(OP_ADD, 16'd1);
    send_word(OP_RUN, 16'd9);

    while (words_sent < 1000) begin
      case ($urandom_range(0, 4))
        0: last = 16'd0;
        1: last = 16'hFFFF;
        2: last = 16'd199;
        default: last = 16'($urandom_range(1, 65535));
      endcase
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), last);
      // One long stretch in the middle of the run sends with no gaps.
      quiet = (words_sent >= 400) && (words_sent < 600);
      repeat ($urandom_range(2, 6)) begin
        k = $urandom_range(0, 99);
        n = (k < 80) ? $urandom_range(0, 8) : (k < 95) ? $urandom_range(9, 31)
                                                        : $urandom_range(32, 36);
        repeat (n) send_word(OP_ADD, pick_cyl());
        send_word(OP_RUN, 16'($urandom_range(0, 65535)));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("disk_head_seek_cost_core regression: pass");
    end else begin
      $display("disk_head_seek_cost_core regression: fail");
    end
    $finish;
  end

endmodule
